[sv/scan_code_to_ascii_fifo_core_assert.svh]
// assertion macros shared by the scan code to ascii core
`ifndef SCAN_CODE_TO_ASCII_FIFO_CORE_ASSERT_SVH
`define SCAN_CODE_TO_ASCII_FIFO_CORE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define SC2A_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in a cycle implies consequent in the next
`define SC2A_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define SC2A_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/sc2a_pkg.sv]
// package with constants and the set-1 scan code table
`timescale 1ns / 1ps
package sc2a_pkg;

    localparam int FIFO_DEPTH_DEF = 64;

    // request kinds
    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [7:0] KEY_LSHIFT = 8'd128;
    localparam logic [7:0] KEY_RSHIFT = 8'd129;
    localparam logic [7:0] KEY_ALT    = 8'd130;

    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    localparam logic [6:0] FILL_MAX = 7'd127;

    // fixed us layout, code 0 for unmapped keys
    function automatic logic [7:0] scan_lookup(input logic [6:0] code);
        logic [7:0] ch;
        ch = 8'h00;
        case (code)
            7'd1:    ch = 8'd27;
            7'd2:    ch = 8'h31;
            7'd3:    ch = 8'h32;
            7'd4:    ch = 8'h33;
            7'd5:    ch = 8'h34;
            7'd6:    ch = 8'h35;
            7'd7:    ch = 8'h36;
            7'd8:    ch = 8'h37;
            7'd9:    ch = 8'h38;
            7'd10:   ch = 8'h39;
            7'd11:   ch = 8'h30;
            7'd12:   ch = 8'h2D;
            7'd13:   ch = 8'h3D;
            7'd14:   ch = 8'd8;
            7'd15:   ch = 8'd9;
            7'd16:   ch = 8'h71;
            7'd17:   ch = 8'h77;
            7'd18:   ch = 8'h65;
            7'd19:   ch = 8'h72;
            7'd20:   ch = 8'h74;
            7'd21:   ch = 8'h79;
            7'd22:   ch = 8'h75;
            7'd23:   ch = 8'h69;
            7'd24:   ch = 8'h6F;
            7'd25:   ch = 8'h70;
            7'd26:   ch = 8'h5B;
            7'd27:   ch = 8'h5D;
            7'd28:   ch = 8'd10;
            7'd30:   ch = 8'h61;
            7'd31:   ch = 8'h73;
            7'd32:   ch = 8'h64;
            7'd33:   ch = 8'h66;
            7'd34:   ch = 8'h67;
            7'd35:   ch = 8'h68;
            7'd36:   ch = 8'h6A;
            7'd37:   ch = 8'h6B;
            7'd38:   ch = 8'h6C;
            7'd39:   ch = 8'h3B;
            7'd40:   ch = 8'h27;
            7'd41:   ch = 8'h60;
            7'd42:   ch = KEY_LSHIFT;
            7'd43:   ch = 8'h5C;
            7'd44:   ch = 8'h7A;
            7'd45:   ch = 8'h78;
            7'd46:   ch = 8'h63;
            7'd47:   ch = 8'h76;
            7'd48:   ch = 8'h62;
            7'd49:   ch = 8'h6E;
            7'd50:   ch = 8'h6D;
            7'd51:   ch = 8'h2C;
            7'd52:   ch = 8'h2E;
            7'd53:   ch = 8'h2F;
            7'd54:   ch = KEY_RSHIFT;
            7'd55:   ch = 8'h2A;
            7'd56:   ch = KEY_ALT;
            7'd57:   ch = 8'h20;
            7'd74:   ch = 8'h2D;
            7'd78:   ch = 8'h2B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[sv/sc2a_req_if.sv]
// request channel: scan code or character read
`timescale 1ns / 1ps
interface sc2a_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] key_code;

    modport source (output valid, output func, output key_code, input ready);
    modport sink (input valid, input func, input key_code, output ready);
endinterface

[sv/sc2a_rsp_if.sv]
// result channel: popped character, drop flag, fill level and modifiers
`timescale 1ns / 1ps
interface sc2a_rsp_if;
    logic       valid;
    logic       ready;
    logic       read_valid;
    logic [7:0] read_char;
    logic       dropped;
    logic [6:0] fill_level;
    logic       shift_active;
    logic       alt_active;

    modport source (output valid, output read_valid, output read_char, output dropped,
                    output fill_level, output shift_active, output alt_active,
                    input ready);
    modport sink (input valid, input read_valid, input read_char, input dropped,
                  input fill_level, input shift_active, input alt_active,
                  output ready);
endinterface

[sv/sc2a_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sc2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[sv/scan_code_to_ascii_fifo_core.sv]
// top level: set-1 scan code decoder with character fifo
`timescale 1ns / 1ps
`include "scan_code_to_ascii_fifo_core_assert.svh"
// Each request either carries a set-1 scan code (func 0) or asks to pop one
// character (func 1) and gives exactly one result. A new request is taken
// every cycle unless a stalled result holds stage one; a result passes
// through s1, beside the registered read of the character ram, and s2. Shift
// and alt state, the fifo pointers and the fill count are updated at the edge
// that takes the request, so back to back requests see each other at once.
// Reading an empty fifo returns read_valid 0; a character that meets a full
// fifo is discarded and flagged in dropped. fill_level saturates at 127.
module scan_code_to_ascii_fifo_core #(
    parameter int FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    sc2a_req_if.sink  req,
    sc2a_rsp_if.source rsp
);
    import sc2a_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int LW = (CW > 7) ? CW : 7;

    typedef struct packed {
        logic       pop;
        logic       dropped;
        logic [6:0] fill_level;
        logic       shift_active;
        logic       alt_active;
    } meta_t;

    // architectural state
    logic          lshift_reg, lshift_next;
    logic          rshift_reg, rshift_next;
    logic          alt_reg, alt_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // pipeline stages
    logic          s1_valid_reg, s1_valid_next;
    meta_t         s1_meta_reg;
    logic          s2_valid_reg, s2_valid_next;
    meta_t         s2_meta_reg;
    logic [7:0]    s2_char_reg;

    logic          in_fire, s1_adv;
    logic [7:0]    table_ch, push_ch, ram_q;
    logic          is_mod, push_try, full, push, pop, drop;
    logic [LW-1:0] cnt_ext;
    meta_t         meta_in;

    // handshake
    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign in_fire   = req.valid && req.ready;

    // decode of the request
    always_comb
    begin
        table_ch = scan_lookup(req.key_code[6:0]);
        is_mod   = (table_ch == KEY_LSHIFT) || (table_ch == KEY_RSHIFT)
                   || (table_ch == KEY_ALT);
        full     = (cnt_reg == CW'(FIFO_DEPTH));
        push_try = (req.func == FUNC_SCAN) && !req.key_code[7] && !is_mod;
        push     = in_fire && push_try && !full;
        drop     = push_try && full;
        pop      = in_fire && (req.func == FUNC_READ) && (cnt_reg != '0);
        push_ch  = table_ch;
        if ((lshift_reg || rshift_reg) && (table_ch >= CHAR_LOWER_A)
            && (table_ch <= CHAR_LOWER_Z))
        begin
            push_ch = table_ch - CASE_OFFSET;
        end
    end

    // modifier flags, pointers and count
    always_comb
    begin
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        alt_next    = alt_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (in_fire && (req.func == FUNC_SCAN))
        begin
            if (table_ch == KEY_LSHIFT)
            begin
                lshift_next = !req.key_code[7];
            end
            if (table_ch == KEY_RSHIFT)
            begin
                rshift_next = !req.key_code[7];
            end
            if (table_ch == KEY_ALT)
            begin
                alt_next = !req.key_code[7];
            end
        end
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            cnt_next    = cnt_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            cnt_next    = cnt_reg - 1'b1;
        end
    end

    // result fields known at accept time
    always_comb
    begin
        cnt_ext              = LW'(cnt_next);
        meta_in.pop          = pop;
        meta_in.dropped      = drop;
        meta_in.fill_level   = (cnt_ext > LW'(FILL_MAX)) ? FILL_MAX : cnt_ext[6:0];
        meta_in.shift_active = lshift_next || rshift_next;
        meta_in.alt_active   = alt_next;
    end

    // stage valids
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (rsp.ready)
        begin
            s2_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
            s1_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lshift_reg   <= 1'b0;
            rshift_reg   <= 1'b0;
            alt_reg      <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            lshift_reg   <= lshift_next;
            rshift_reg   <= rshift_next;
            alt_reg      <= alt_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_meta_reg <= meta_in;
        end
        if (s1_adv)
        begin
            s2_meta_reg <= s1_meta_reg;
            s2_char_reg <= s1_meta_reg.pop ? ram_q : 8'h00;
        end
    end

    // character store
    sc2a_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_char_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (push_ch),
        .re    (pop),
        .raddr (rd_ptr_reg),
        .rdata (ram_q)
    );

    // result port
    assign rsp.valid        = s2_valid_reg;
    assign rsp.read_valid   = s2_meta_reg.pop;
    assign rsp.read_char    = s2_char_reg;
    assign rsp.dropped      = s2_meta_reg.dropped;
    assign rsp.fill_level   = s2_meta_reg.fill_level;
    assign rsp.shift_active = s2_meta_reg.shift_active;
    assign rsp.alt_active   = s2_meta_reg.alt_active;

    // checks
    `SC2A_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CW'(FIFO_DEPTH), "fifo count above depth")
    `SC2A_ASSERT_SAME(a_no_push_pop, push, !pop, "push and pop for one request")
    `SC2A_ASSERT_NEXT(a_empty_read,
        in_fire && (req.func == FUNC_READ) && (cnt_reg == '0),
        $stable(cnt_reg) && $stable(rd_ptr_reg), "empty read changed fifo state")
    `SC2A_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(s1_meta_reg), "stalled stage one lost its request")
    `SC2A_ASSERT_SAME(a_drop_full, rsp.valid && rsp.dropped, !rsp.read_valid,
        "drop flagged on a read result")
endmodule

[tb/tb_scan_code_to_ascii_fifo_core.sv]
// testbench for the set-1 scan code to ascii core with its character fifo
`timescale 1ns / 1ps
module tb_scan_code_to_ascii_fifo_core;

    import sc2a_pkg::*;

    // set-1 scan codes used by name
    localparam logic [7:0] SC_NONE    = 8'h00;
    localparam logic [7:0] SC_1       = 8'h02;
    localparam logic [7:0] SC_Q       = 8'h10;
    localparam logic [7:0] SC_A       = 8'h1E;
    localparam logic [7:0] SC_LSHIFT  = 8'h2A;
    localparam logic [7:0] SC_Z       = 8'h2C;
    localparam logic [7:0] SC_RSHIFT  = 8'h36;
    localparam logic [7:0] SC_ALT     = 8'h38;
    localparam logic [7:0] SC_KP_PLUS = 8'h4E;
    localparam logic [7:0] SC_TOP     = 8'h7F;
    localparam logic [7:0] SC_RELEASE = 8'h80;

    localparam int DEPTH      = FIFO_DEPTH_DEF;
    localparam int RAND_ITEMS = 240;
    localparam int CALM_ITEMS = 80;
    localparam int SEG_ITEMS  = 30;
    localparam int LONG_HOLD  = 150;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_char;
        logic       dropped;
        logic [6:0] fill_level;
        logic       shift_active;
        logic       alt_active;
    } key_result_t;

    typedef struct packed {
        logic        func;
        logic [7:0]  code;
        logic        typed;
        key_result_t want;
    } stim_row_t;

    localparam key_result_t NO_RESULT = '0;

    // directed requests; typed rows carry their result, the rest use the predictor
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{FUNC_READ, SC_NONE,                1'b1, {1'b0, 8'h00, 1'b0, 7'd0, 1'b0, 1'b0}},
        '{FUNC_SCAN, SC_NONE,                1'b1, {1'b0, 8'h00, 1'b0, 7'd1, 1'b0, 1'b0}},
        '{FUNC_SCAN, SC_A,                   1'b0, NO_RESULT},
        '{FUNC_SCAN, SC_LSHIFT,              1'b1, {1'b0, 8'h00, 1'b0, 7'd2, 1'b1, 1'b0}},
        '{FUNC_SCAN, SC_A,                   1'b0, NO_RESULT},
        '{FUNC_SCAN, SC_Z,                   1'b0, NO_RESULT},
        '{FUNC_SCAN, SC_1,                   1'b0, NO_RESULT},
        '{FUNC_SCAN, SC_LSHIFT | SC_RELEASE, 1'b1, {1'b0, 8'h00, 1'b0, 7'd5, 1'b0, 1'b0}},
        '{FUNC_SCAN, SC_RSHIFT,              1'b1, {1'b0, 8'h00, 1'b0, 7'd5, 1'b1, 1'b0}},
        '{FUNC_SCAN, SC_Z,                   1'b0, NO_RESULT},
        '{FUNC_SCAN, SC_LSHIFT,              1'b0, NO_RESULT},
        '{FUNC_SCAN, SC_RSHIFT | SC_RELEASE, 1'b1, {1'b0, 8'h00, 1'b0, 7'd6, 1'b1, 1'b0}},
        '{FUNC_SCAN, SC_A,                   1'b0, NO_RESULT},
        '{FUNC_SCAN, SC_LSHIFT | SC_RELEASE, 1'b0, NO_RESULT},
        '{FUNC_SCAN, SC_ALT,                 1'b1, {1'b0, 8'h00, 1'b0, 7'd7, 1'b0, 1'b1}},
        '{FUNC_SCAN, SC_Q,                   1'b0, NO_RESULT},
        '{FUNC_SCAN, SC_ALT | SC_RELEASE,    1'b0, NO_RESULT},
        '{FUNC_SCAN, SC_TOP,                 1'b0, NO_RESULT},
        '{FUNC_SCAN, SC_TOP | SC_RELEASE,    1'b1, {1'b0, 8'h00, 1'b0, 7'd9, 1'b0, 1'b0}},
        '{FUNC_SCAN, SC_A | SC_RELEASE,      1'b0, NO_RESULT},
        '{FUNC_READ, 8'hFF,                  1'b1, {1'b1, 8'h00, 1'b0, 7'd8, 1'b0, 1'b0}},
        '{FUNC_READ, SC_NONE,                1'b1, {1'b1, 8'h61, 1'b0, 7'd7, 1'b0, 1'b0}},
        '{FUNC_READ, SC_NONE,                1'b0, NO_RESULT},
        '{FUNC_SCAN, SC_KP_PLUS,             1'b0, NO_RESULT},
        '{FUNC_READ, SC_NONE,                1'b0, NO_RESULT}
    };

    // share of reads per random segment, low values drive the fifo to full
    localparam int READ_PCT [8] = '{10, 60, 90, 40, 15, 75, 50, 50};

    // us keymap for codes 0..79, higher codes are unmapped
    logic [7:0] us_keymap [80] = '{
        8'h00, 8'd27, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, KEY_LSHIFT, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, KEY_RSHIFT, 8'h2A, KEY_ALT, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00
    };

    logic clk;
    logic rst_n;

    sc2a_req_if req_ch ();
    sc2a_rsp_if rsp_ch ();

    scan_code_to_ascii_fifo_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // mirror of the keyboard state and character fifo
    logic        lshift_held;
    logic        rshift_held;
    logic        alt_held;
    logic [7:0]  char_mirror [DEPTH];
    int          wr_idx;
    int          rd_idx;
    int          held_chars;

    key_result_t key_results_due [$];
    int          errors;
    int          n_requests;
    int          n_pushed;
    int          n_popped;
    int          n_dropped;
    int          n_empty_reads;
    bit          calm;
    int          long_hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // predicted result of one request, updates the mirror state
    function automatic key_result_t predict_keyboard(input logic f, input logic [7:0] code);
        key_result_t r;
        logic [7:0]  ch;
        r = '0;
        if (f == FUNC_READ)
        begin
            if (held_chars > 0)
            begin
                r.read_valid = 1'b1;
                r.read_char  = char_mirror[rd_idx];
                rd_idx       = (rd_idx == DEPTH - 1) ? 0 : rd_idx + 1;
                held_chars--;
                n_popped++;
            end
            else
            begin
                n_empty_reads++;
            end
        end
        else
        begin
            ch = (code[6:0] < 7'd80) ? us_keymap[code[6:0]] : 8'h00;
            if (code[7])
            begin
                // release only matters for the modifiers
                if (ch == KEY_LSHIFT)
                    lshift_held = 1'b0;
                else if (ch == KEY_RSHIFT)
                    rshift_held = 1'b0;
                else if (ch == KEY_ALT)
                    alt_held = 1'b0;
            end
            else if (ch == KEY_LSHIFT)
                lshift_held = 1'b1;
            else if (ch == KEY_RSHIFT)
                rshift_held = 1'b1;
            else if (ch == KEY_ALT)
                alt_held = 1'b1;
            else
            begin
                if ((lshift_held || rshift_held) && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
                    ch = ch - CASE_OFFSET;
                if (held_chars < DEPTH)
                begin
                    char_mirror[wr_idx] = ch;
                    wr_idx              = (wr_idx == DEPTH - 1) ? 0 : wr_idx + 1;
                    held_chars++;
                    n_pushed++;
                end
                else
                begin
                    r.dropped = 1'b1;
                    n_dropped++;
                end
            end
        end
        r.fill_level   = (held_chars > FILL_MAX) ? FILL_MAX : 7'(held_chars);
        r.shift_active = lshift_held | rshift_held;
        r.alt_active   = alt_held;
        return r;
    endfunction

    // offer one request, optionally after an idle burst, and queue its result
    task automatic send_req(input logic f, input logic [7:0] code, input logic typed,
                            input key_result_t want);
        key_result_t predicted;
        int          gap;
        gap = (!calm && $urandom_range(0, 99) < 20) ? $urandom_range(1, 9) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= f;
        req_ch.key_code <= code;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = predict_keyboard(f, code);
        key_results_due.push_back(typed ? want : predicted);
        n_requests++;
    endtask

    // stop offering and hold the sender until every queued result has come back
    task automatic wait_results_done();
        req_ch.valid <= 1'b0;
        while (key_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // result side: random stall bursts plus one long hold-off on request
    initial
    begin : rsp_ready_drive
        int hold;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                long_hold_cycles--;
            end
            else if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else if (!calm && $urandom_range(0, 99) < 15)
            begin
                hold = $urandom_range(1, 9) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : rsp_monitor
        key_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (key_results_due.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                want = key_results_due.pop_front();
                check_field("read_valid", want.read_valid, rsp_ch.read_valid);
                check_field("read_char", want.read_char, rsp_ch.read_char);
                check_field("dropped", want.dropped, rsp_ch.dropped);
                check_field("fill_level", want.fill_level, rsp_ch.fill_level);
                check_field("shift_active", want.shift_active, rsp_ch.shift_active);
                check_field("alt_active", want.alt_active, rsp_ch.alt_active);
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int         k;
        int         roll;
        logic       f;
        logic [7:0] code;

        lshift_held      = 1'b0;
        rshift_held      = 1'b0;
        alt_held         = 1'b0;
        wr_idx           = 0;
        rd_idx           = 0;
        held_chars       = 0;
        errors           = 0;
        n_requests       = 0;
        n_pushed         = 0;
        n_popped         = 0;
        n_dropped        = 0;
        n_empty_reads    = 0;
        calm             = 1'b0;
        long_hold_cycles = 0;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.func     <= FUNC_SCAN;
        req_ch.key_code <= SC_NONE;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (DIRECTED_ROWS[i])
            send_req(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].code,
                     DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        wait_results_done();

        // result side holds off while letters keep coming: fifo fills, input stalls
        long_hold_cycles = LONG_HOLD;
        for (k = 0; k < 70; k++)
            send_req(FUNC_SCAN, 8'($urandom_range(16, 25)), 1'b0, NO_RESULT);
        wait_results_done();

        // drain past empty
        for (k = 0; k < 70; k++)
            send_req(FUNC_READ, 8'($urandom), 1'b0, NO_RESULT);
        wait_results_done();

        // random typing in segments of varying read share
        for (k = 0; k < RAND_ITEMS; k++)
        begin
            if (k == RAND_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < READ_PCT[k / SEG_ITEMS])
            begin
                f    = FUNC_READ;
                code = 8'($urandom);
            end
            else
            begin
                f    = FUNC_SCAN;
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    code = 8'($urandom);
                else if (roll < 30)
                begin
                    case ($urandom_range(0, 2))
                        0:       code = SC_LSHIFT;
                        1:       code = SC_RSHIFT;
                        default: code = SC_ALT;
                    endcase
                    if (roll >= 20)
                        code = code | SC_RELEASE;
                end
                else if (roll < 38)
                    code = SC_RELEASE | 8'($urandom_range(0, 127));
                else if (roll < 93)
                    code = 8'($urandom_range(1, 57));
                else
                    code = 8'($urandom_range(58, 127));
            end
            send_req(f, code, 1'b0, NO_RESULT);
        end
        req_ch.valid <= 1'b0;

        wait_results_done();
        repeat (12) @(posedge clk);

        $display("run covered %0d requests: %0d characters pushed, %0d popped",
                 n_requests, n_pushed, n_popped);
        $display("full fifo drops %0d, reads of an empty fifo %0d", n_dropped, n_empty_reads);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
